[design/scwp_pkg.sv]
package scwp_pkg;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);

    localparam logic [7:0] CodeReply    = 8'hFF;
    localparam logic [7:0] CodeReset    = 8'hFE;
    localparam logic [3:0] NibSelect    = 4'h0;
    localparam logic [7:0] CodeSlotOne  = 8'h01;
    localparam logic [3:0] NibWritePair = 4'h0;
    localparam logic [3:0] NibWriteOne  = 4'h8;
    localparam logic [3:0] NibWriteZero = 4'h2;
    localparam logic [7:0] CodeWriteZero = 8'h20;

    localparam logic [7:0] CharR = 8'h52;
    localparam logic [7:0] CharS = 8'h53;
    localparam logic [7:0] CharO = 8'h4F;
    localparam logic [7:0] CharK = 8'h4B;

    localparam logic [15:0] AfterByteReset   = 16'd10000;
    localparam logic [15:0] ReloadIdleReset  = 16'd1000;
    localparam logic [15:0] CountReset       = 16'd2000;

    localparam logic CfgAfterByte  = 1'b0;
    localparam logic CfgReloadIdle = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_CMD   = 2'd1,
        PH_DATA1 = 2'd2,
        PH_DATA2 = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_TX    = 2'd1,
        KIND_RESET = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        JOB_WRITE = 2'd0,
        JOB_REPLY = 2'd1,
        JOB_RESET = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind  kind;
        logic       slot;
        logic [3:0] addr;
        logic [7:0] data;
    } t_job;

endpackage

[design/scwp_front.sv]
module scwp_front import scwp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_q_full,
    output logic        o_push,
    output t_job        o_job
);

    t_phase      r_phase, n_phase;
    logic        r_slot, n_slot;
    logic [3:0]  r_addr, n_addr;
    logic [7:0]  r_cmd, n_cmd;
    logic [15:0] r_count, n_count;
    logic [15:0] r_after, r_reload;

    logic        accept, is_byte, is_tick;
    logic [15:0] count_dec;
    logic [3:0]  hi;
    logic [3:0]  cmd_hi;

    assign o_s_tready  = !i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_s_tvalid && !i_q_full;
    assign is_byte     = accept && !i_s_tuser;
    assign is_tick     = accept && i_s_tuser;
    assign count_dec   = r_count - 16'd1;
    assign hi          = i_s_tdata[7:4];
    assign cmd_hi      = r_cmd[7:4];

    always_comb begin
        n_phase = r_phase;
        n_slot  = r_slot;
        n_addr  = r_addr;
        n_cmd   = r_cmd;
        n_count = r_count;
        if (is_tick) begin
            n_count = count_dec;
            if (count_dec == 16'd0) begin
                n_phase = PH_IDLE;
                n_count = r_reload;
            end
        end
        if (is_byte) begin
            n_count = r_after;
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_s_tdata != CodeReply && i_s_tdata != CodeReset
                        && hi == NibSelect) begin
                        n_slot  = (i_s_tdata == CodeSlotOne);
                        n_phase = PH_CMD;
                    end
                end
                PH_CMD: begin
                    n_phase = PH_DATA1;
                    if (hi == NibWritePair || hi == NibWriteOne) begin
                        n_addr = i_s_tdata[3:0];
                        n_cmd  = i_s_tdata;
                    end else if (hi == NibWriteZero) begin
                        n_cmd = i_s_tdata;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_DATA1: begin
                    if (cmd_hi == NibWritePair) begin
                        n_phase = PH_DATA2;
                    end else if (cmd_hi == NibWriteOne || r_cmd == CodeWriteZero) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_DATA2: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_push     = 1'b0;
        o_job.kind = JOB_WRITE;
        o_job.slot = r_slot;
        o_job.addr = r_addr;
        o_job.data = i_s_tdata;
        if (is_byte) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_s_tdata == CodeReply) begin
                        o_push     = 1'b1;
                        o_job.kind = JOB_REPLY;
                    end else if (i_s_tdata == CodeReset) begin
                        o_push     = 1'b1;
                        o_job.kind = JOB_RESET;
                    end
                end
                PH_CMD: begin
                    o_push = 1'b0;
                end
                PH_DATA1: begin
                    if (cmd_hi == NibWritePair || cmd_hi == NibWriteOne) begin
                        o_push = 1'b1;
                    end else if (r_cmd == CodeWriteZero) begin
                        o_push     = 1'b1;
                        o_job.addr = 4'd0;
                    end
                end
                PH_DATA2: begin
                    o_push     = 1'b1;
                    o_job.addr = r_addr | 4'd1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_slot   <= 1'b0;
            r_addr   <= 4'd0;
            r_cmd    <= 8'd0;
            r_count  <= CountReset;
            r_after  <= AfterByteReset;
            r_reload <= ReloadIdleReset;
        end else begin
            r_phase <= n_phase;
            r_slot  <= n_slot;
            r_addr  <= n_addr;
            r_cmd   <= n_cmd;
            r_count <= n_count;
            if (i_cfg_valid) begin
                if (i_cfg_index == CfgAfterByte) begin
                    r_after <= i_cfg_data;
                end else if (i_cfg_index == CfgReloadIdle) begin
                    r_reload <= i_cfg_data;
                end
            end
        end
    end

endmodule

[design/scwp_queue.sv]
module scwp_queue import scwp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job                 r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wr, r_rd;
    logic [QueuePtrW:0]   r_cnt;
    logic                 do_push, do_pop;

    assign o_full  = (r_cnt == QueuePtrW'(0) + (QueuePtrW+1)'(QueueDepth));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QueuePtrW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QueuePtrW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (QueuePtrW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (QueuePtrW+1)'(1);
            end
        end
    end

endmodule

[design/scwp_back.sv]
module scwp_back import scwp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,
    output logic [1:0]  o_m_tuser,
    output logic        o_m_tlast
);

    logic [1:0] r_step;
    logic       r_valid;
    t_kind      r_kind;
    logic       r_slot;
    logic [3:0] r_addr;
    logic [7:0] r_data;
    logic [7:0] r_tx;
    logic       r_last;

    logic       load;
    t_kind      w_kind;
    logic       w_slot;
    logic [3:0] w_addr;
    logic [7:0] w_data;
    logic [7:0] w_tx;
    logic       w_last;

    assign load  = i_q_valid && (!r_valid || i_m_tready);
    assign o_pop = load && w_last;

    always_comb begin
        w_kind = KIND_TX;
        w_slot = 1'b0;
        w_addr = 4'd0;
        w_data = 8'd0;
        w_tx   = 8'd0;
        w_last = 1'b0;
        unique case (i_job.kind)
            JOB_WRITE: begin
                w_kind = KIND_WRITE;
                w_slot = i_job.slot;
                w_addr = i_job.addr;
                w_data = i_job.data;
                w_last = 1'b1;
            end
            JOB_REPLY: begin
                w_tx   = (r_step == 2'd0) ? CharR : CharS;
                w_last = (r_step != 2'd0);
            end
            JOB_RESET: begin
                if (r_step == 2'd0) begin
                    w_kind = KIND_RESET;
                end else begin
                    w_tx = (r_step == 2'd1) ? CharO : CharK;
                end
                w_last = (r_step == 2'd2);
            end
            default: begin
                w_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= w_kind;
            r_slot <= w_slot;
            r_addr <= w_addr;
            r_data <= w_data;
            r_tx   <= w_tx;
            r_last <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_step  <= w_last ? 2'd0 : r_step + 2'd1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_kind;
    assign o_m_tlast  = r_last;
    assign o_m_tdata  = {3'd0, r_tx, r_data, r_addr, r_slot};

endmodule

[design/serial_command_to_bus_write_parser.sv]
// Parses serial command bytes and timing ticks into bus writes, chip reset pulses and
// reply characters. One input word (a byte or a tick) is accepted every clock cycle; the
// parser phase and the timeout counter update in that same cycle. Words that cause output
// place one job in a four-entry queue, and the output side turns each job into one result
// word per cycle while the consumer is ready: one for a bus write, two for a status reply,
// three for a reset request. The input stalls only while that queue is full, and output
// words are registered, so a stalled consumer does not block input until four jobs are
// pending. Configuration writes are accepted in every cycle.
module serial_command_to_bus_write_parser import scwp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_s_tuser,   // [0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [0] bus_slot, [4:1] bus_addr, [12:5] bus_data, [20:13] tx_byte
    output logic [1:0]  o_m_tuser,   // [1:0] result_kind
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic q_full, q_push, q_valid, q_pop;
    t_job push_job, head_job;

    scwp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (push_job)
    );

    scwp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    scwp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_job      (head_job),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
